// ===== src/tun_pkg.sv =====
// Shared types and constants for the triangle unit normal pipeline.
// Used by every module of the block; depends on nothing.
package tun_pkg;

    localparam int AXES = 3;

    typedef enum int {
        AX_X = 0,
        AX_Y = 1,
        AX_Z = 2
    } axis_t;

    // Control that travels alongside each item through the stages.
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

// ===== src/tun_if.sv =====
// Handshake channels of the triangle unit normal block: vertices in, normal out.
// Stand-alone; no package is needed.
interface tun_vtx_if #(parameter int CW = 24);
    logic valid;
    logic ready;
    logic signed [CW-1:0] a_x, a_y, a_z;
    logic signed [CW-1:0] b_x, b_y, b_z;
    logic signed [CW-1:0] c_x, c_y, c_z;
    logic last_in;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_in,
                    input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, last_in,
                  output ready);
endinterface

interface tun_nrm_if #(parameter int OW = 18);
    logic valid;
    logic ready;
    logic signed [OW-1:0] norm_x, norm_y, norm_z;
    logic degenerate;
    logic last_out;

    modport source (output valid, norm_x, norm_y, norm_z, degenerate, last_out,
                    input ready);
    modport sink (input valid, norm_x, norm_y, norm_z, degenerate, last_out,
                  output ready);
endinterface

// ===== src/tun_cross.sv =====
// Edge differences and exact cross product, three register stages.
// Depends on tun_pkg and tun_vtx_if.
module tun_cross #(
    parameter int CW = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    tun_vtx_if.sink              vtx,
    output tun_pkg::tag_t        tag_o,
    output logic [2*CW+1:0]      mag_o [tun_pkg::AXES],
    output logic                 neg_o [tun_pkg::AXES]
);
    localparam int D  = CW + 1;
    localparam int PW = 2 * D;

    tun_pkg::tag_t tag_a_reg, tag_b_reg, tag_c_reg;
    logic signed [D-1:0]  e_reg [tun_pkg::AXES];
    logic signed [D-1:0]  f_reg [tun_pkg::AXES];
    logic signed [PW-1:0] p_reg [2*tun_pkg::AXES];
    logic [PW-1:0]        mag_reg [tun_pkg::AXES];
    logic                 neg_reg [tun_pkg::AXES];

    logic signed [D-1:0]  e_next [tun_pkg::AXES];
    logic signed [D-1:0]  f_next [tun_pkg::AXES];
    logic signed [PW:0]   t_next [tun_pkg::AXES];
    logic [PW:0]          abs_next [tun_pkg::AXES];

    assign vtx.ready = en;

    always_comb
    begin
        e_next[tun_pkg::AX_X] = $signed({vtx.b_x[CW-1], vtx.b_x}) - $signed({vtx.a_x[CW-1], vtx.a_x});
        e_next[tun_pkg::AX_Y] = $signed({vtx.b_y[CW-1], vtx.b_y}) - $signed({vtx.a_y[CW-1], vtx.a_y});
        e_next[tun_pkg::AX_Z] = $signed({vtx.b_z[CW-1], vtx.b_z}) - $signed({vtx.a_z[CW-1], vtx.a_z});
        f_next[tun_pkg::AX_X] = $signed({vtx.c_x[CW-1], vtx.c_x}) - $signed({vtx.a_x[CW-1], vtx.a_x});
        f_next[tun_pkg::AX_Y] = $signed({vtx.c_y[CW-1], vtx.c_y}) - $signed({vtx.a_y[CW-1], vtx.a_y});
        f_next[tun_pkg::AX_Z] = $signed({vtx.c_z[CW-1], vtx.c_z}) - $signed({vtx.a_z[CW-1], vtx.a_z});
        for (int k = 0; k < tun_pkg::AXES; k++)
        begin
            t_next[k] = $signed({p_reg[2*k][PW-1], p_reg[2*k]})
                      - $signed({p_reg[2*k+1][PW-1], p_reg[2*k+1]});
            abs_next[k] = t_next[k][PW] ? (PW+1)'(-t_next[k]) : t_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= '{valid: vtx.valid, last: vtx.last_in};
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
            f_reg <= f_next;
            // Each component is a*b - c*d; the two products sit side by side.
            p_reg[0] <= e_reg[tun_pkg::AX_Y] * f_reg[tun_pkg::AX_Z];
            p_reg[1] <= e_reg[tun_pkg::AX_Z] * f_reg[tun_pkg::AX_Y];
            p_reg[2] <= e_reg[tun_pkg::AX_Z] * f_reg[tun_pkg::AX_X];
            p_reg[3] <= e_reg[tun_pkg::AX_X] * f_reg[tun_pkg::AX_Z];
            p_reg[4] <= e_reg[tun_pkg::AX_X] * f_reg[tun_pkg::AX_Y];
            p_reg[5] <= e_reg[tun_pkg::AX_Y] * f_reg[tun_pkg::AX_X];
            for (int k = 0; k < tun_pkg::AXES; k++)
            begin
                mag_reg[k] <= abs_next[k][PW-1:0];
                neg_reg[k] <= t_next[k][PW];
            end
        end
    end

    assign tag_o = tag_c_reg;
    assign mag_o = mag_reg;
    assign neg_o = neg_reg;
endmodule

// ===== src/tun_sqrt.sv =====
// Sum of squares of the cross product and its floor square root, one root bit a stage.
// Depends on tun_pkg.
module tun_sqrt #(
    parameter int MW = 50
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tun_pkg::tag_t   tag_i,
    input  logic [MW-1:0]   mag_i [tun_pkg::AXES],
    input  logic            neg_i [tun_pkg::AXES],
    output tun_pkg::tag_t   tag_o,
    output logic [MW-1:0]   mag_o [tun_pkg::AXES],
    output logic            neg_o [tun_pkg::AXES],
    output logic [MW:0]     root_o
);
    localparam int H   = (MW + 1) / 2;
    localparam int HW  = MW - H;
    localparam int SQW = 2 * MW;
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = MW + 1;
    localparam int NS  = RW + 3;

    // Items travel with their magnitudes and signs through every stage.
    tun_pkg::tag_t tag_reg [NS];
    logic [MW-1:0] mag_reg [NS][tun_pkg::AXES];
    logic          neg_reg [NS][tun_pkg::AXES];

    logic [2*HW-1:0]   hh_reg [tun_pkg::AXES];
    logic [HW+H-1:0]   hl_reg [tun_pkg::AXES];
    logic [2*H-1:0]    ll_reg [tun_pkg::AXES];
    logic [SQW-1:0]    sq_reg [tun_pkg::AXES];
    logic [SW-1:0]     sum_reg;

    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SW-1:0]     sv_reg   [RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                tag_reg[s] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_i;
            for (int s = 1; s < NS; s++)
                tag_reg[s] <= tag_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= mag_i;
            neg_reg[0] <= neg_i;
            for (int s = 1; s < NS; s++)
            begin
                mag_reg[s] <= mag_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            for (int k = 0; k < tun_pkg::AXES; k++)
            begin
                hh_reg[k] <= mag_i[k][MW-1:H] * mag_i[k][MW-1:H];
                hl_reg[k] <= mag_i[k][MW-1:H] * mag_i[k][H-1:0];
                ll_reg[k] <= mag_i[k][H-1:0] * mag_i[k][H-1:0];
                sq_reg[k] <= (SQW'(hh_reg[k]) << (2 * H)) + (SQW'(hl_reg[k]) << (H + 1))
                           + SQW'(ll_reg[k]);
            end
            sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_root
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] sv_in;
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign sv_in   = sum_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sv_in   = sv_reg[k-1];
        end

        assign cur   = {rem_in, sv_in[SW-1:SW-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (cur >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? (RW+2)'(cur - trial) : cur[RW+1:0];
                root_reg[k] <= {root_in[RW-2:0], take};
                sv_reg[k]   <= {sv_in[SW-3:0], 2'b00};
            end
        end
    end

    assign tag_o  = tag_reg[NS-1];
    assign mag_o  = mag_reg[NS-1];
    assign neg_o  = neg_reg[NS-1];
    assign root_o = root_reg[RW-1];
endmodule

// ===== src/tun_div.sv =====
// Restoring division of each magnitude by the root, one quotient bit a stage,
// then sign and degenerate handling into the output register. Depends on tun_pkg, tun_nrm_if.
module tun_div #(
    parameter int MW   = 50,
    parameter int FRAC = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tun_pkg::tag_t   tag_i,
    input  logic [MW-1:0]   mag_i [tun_pkg::AXES],
    input  logic            neg_i [tun_pkg::AXES],
    input  logic [MW:0]     root_i,
    tun_nrm_if.source       nrm
);
    localparam int RW = MW + 1;
    localparam int DW = RW + 1;
    localparam int NS = FRAC + 1;
    localparam int OW = FRAC + 2;

    tun_pkg::tag_t tag_reg [NS];
    logic          degen_reg [NS];
    logic [RW-1:0] m_reg [NS];
    logic          neg_reg [NS][tun_pkg::AXES];
    logic [DW-1:0] r_reg [NS][tun_pkg::AXES];
    logic [FRAC:0] q_reg [NS][tun_pkg::AXES];

    tun_pkg::tag_t         tag_out_reg;
    logic                  degen_out_reg;
    logic signed [OW-1:0]  norm_reg [tun_pkg::AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                tag_reg[s] <= '0;
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_i;
            for (int s = 1; s < NS; s++)
                tag_reg[s] <= tag_reg[s-1];
            tag_out_reg <= tag_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]     <= root_i;
            degen_reg[0] <= (root_i == '0);
            neg_reg[0]   <= neg_i;
            for (int s = 1; s < NS; s++)
            begin
                m_reg[s]     <= m_reg[s-1];
                degen_reg[s] <= degen_reg[s-1];
                neg_reg[s]   <= neg_reg[s-1];
            end
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_step
        for (genvar k = 0; k < tun_pkg::AXES; k++)
        begin : g_axis
            logic [DW-1:0] r_in;
            logic [FRAC:0] q_in;
            logic [DW-1:0] m_ext;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign r_in  = DW'(mag_i[k]);
                assign q_in  = '0;
                assign m_ext = DW'(root_i);
            end
            else
            begin : g_next
                assign r_in  = {r_reg[j-1][k][DW-2:0], 1'b0};
                assign q_in  = q_reg[j-1][k];
                assign m_ext = DW'(m_reg[j-1]);
            end

            assign ge = (r_in >= m_ext);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j][k] <= ge ? (r_in - m_ext) : r_in;
                    q_reg[j][k] <= {q_in[FRAC-1:0], ge};
                end
            end
        end
    end

    // The magnitude never exceeds the root, so the quotient tops out at one.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_out_reg <= degen_reg[NS-1];
            for (int k = 0; k < tun_pkg::AXES; k++)
            begin
                if (degen_reg[NS-1])
                    norm_reg[k] <= '0;
                else if (neg_reg[NS-1][k])
                    norm_reg[k] <= -$signed(OW'(q_reg[NS-1][k]));
                else
                    norm_reg[k] <= $signed(OW'(q_reg[NS-1][k]));
            end
        end
    end

    assign nrm.valid      = tag_out_reg.valid;
    assign nrm.last_out   = tag_out_reg.last;
    assign nrm.degenerate = degen_out_reg;
    assign nrm.norm_x     = norm_reg[tun_pkg::AX_X];
    assign nrm.norm_y     = norm_reg[tun_pkg::AX_Y];
    assign nrm.norm_z     = norm_reg[tun_pkg::AX_Z];
endmodule

// ===== src/triangle_unit_normal.sv =====
// Triangle unit normal: top level of the pipeline.
// Depends on tun_pkg, tun_if, tun_cross, tun_sqrt and tun_div.
//
// Usage
//   vtx carries one triangle per item: vertices A, B and C as signed fixed-point
//   coordinates and a last marker. nrm returns one item per triangle: the unit
//   normal of (B-A) x (C-A) with FRAC_BITS fraction bits, a degenerate flag
//   (normal forced to zero when the cross product vanishes) and the last marker.
//   Items leave in the order they arrive.
// Timing
//   The square root takes one root bit per stage and the divider one quotient
//   bit per stage, and these two chains set the depth. A new item is accepted
//   every cycle unless the pipeline holds for a stall.
// Stalls
//   The whole pipeline holds while a result waits and nrm.ready is low; vtx.ready
//   then falls, and no item is dropped or duplicated. Bubbles in the pipe do not
//   hold it up, so vtx.ready stays high while the output register is empty.
// Reset
//   rst_n clears the valid bits of every stage; the data registers are not reset.
module triangle_unit_normal #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    tun_vtx_if.sink    vtx,
    tun_nrm_if.source  nrm
);
    localparam int MW  = 2 * (COORD_WIDTH + 1);
    localparam int LIM = 2 ** FRAC_BITS;

    logic          en;
    tun_pkg::tag_t cross_tag, root_tag;
    logic [MW-1:0] cross_mag [tun_pkg::AXES];
    logic          cross_neg [tun_pkg::AXES];
    logic [MW-1:0] root_mag [tun_pkg::AXES];
    logic          root_neg [tun_pkg::AXES];
    logic [MW:0]   root;

    assign en = !nrm.valid || nrm.ready;

    tun_cross #(.CW(COORD_WIDTH)) u_cross (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vtx   (vtx),
        .tag_o (cross_tag),
        .mag_o (cross_mag),
        .neg_o (cross_neg)
    );

    tun_sqrt #(.MW(MW)) u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .tag_i  (cross_tag),
        .mag_i  (cross_mag),
        .neg_i  (cross_neg),
        .tag_o  (root_tag),
        .mag_o  (root_mag),
        .neg_o  (root_neg),
        .root_o (root)
    );

    tun_div #(.MW(MW), .FRAC(FRAC_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .tag_i  (root_tag),
        .mag_i  (root_mag),
        .neg_i  (root_neg),
        .root_i (root),
        .nrm    (nrm)
    );

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid && nrm.degenerate |-> nrm.norm_x == 0 && nrm.norm_y == 0 && nrm.norm_z == 0)
        else $error("degenerate result with a nonzero component");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid |-> $signed(nrm.norm_x) <= LIM && $signed(nrm.norm_x) >= -LIM
                   && $signed(nrm.norm_y) <= LIM && $signed(nrm.norm_y) >= -LIM
                   && $signed(nrm.norm_z) <= LIM && $signed(nrm.norm_z) >= -LIM)
        else $error("normal component beyond unit length");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid && !nrm.degenerate |-> nrm.norm_x != 0 || nrm.norm_y != 0 || nrm.norm_z != 0)
        else $error("regular triangle gave an all-zero normal");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid && !nrm.ready |=> nrm.valid && !vtx.ready || nrm.ready)
        else $error("pipeline moved during a stall");
endmodule
